// ===== hdl/dsfg_pkg.sv =====
package dsfg_pkg;

    // Configuration register width, enable register width and cause bitmap width.
    localparam int CFG_BITS    = 32;
    localparam int ENABLE_BITS = 6;
    localparam int CAUSE_BITS  = 4;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_EST_MAX_AGE   = 2'd0;
    localparam logic [1:0] REG_CMD_MAX_AGE   = 2'd1;
    localparam logic [1:0] REG_TARGET_PERIOD = 2'd2;
    localparam logic [1:0] REG_CHECK_ENABLES = 2'd3;

    // Register reset values.
    localparam logic [CFG_BITS-1:0]    RST_MAX_AGE       = 32'd100000;
    localparam logic [CFG_BITS-1:0]    RST_TARGET_PERIOD = 32'd2000;
    localparam logic [ENABLE_BITS-1:0] RST_ENABLES       = 6'h3F;

    // Bit positions of the per-stream enable group.
    localparam int EN_STAMP = 0;
    localparam int EN_ID    = 1;
    localparam int EN_MONO  = 2;

    // Bit positions of the failure cause bitmap.
    localparam int CAUSE_MISSING   = 0;
    localparam int CAUSE_TOO_OLD   = 1;
    localparam int CAUSE_ZERO_ID   = 2;
    localparam int CAUSE_BACKWARDS = 3;

    // Fault codes.
    localparam logic [1:0] FAULT_NONE        = 2'd0;
    localparam logic [1:0] FAULT_CMD_TIMEOUT = 2'd1;
    localparam logic [1:0] FAULT_EST_INVALID = 2'd2;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [CFG_BITS-1:0]    est_max_age;
        logic [CFG_BITS-1:0]    cmd_max_age;
        logic [CFG_BITS-1:0]    target_period;
        logic [ENABLE_BITS-1:0] enables;
    } cfg_t;

    // Pipeline moves: load takes a new word into the first stage,
    // retire moves the first stage into the output stage.
    typedef struct packed {
        logic load;
        logic retire;
    } pipe_ctrl_t;

endpackage

// ===== hdl/dsfg_cfg.sv =====
module dsfg_cfg
    import dsfg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [CFG_BITS-1:0] pwdata,
    output logic [CFG_BITS-1:0] prdata,
    output logic                pready,
    output cfg_t                cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] reg_index;
    logic       wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign wr_en     = psel && penable && pwrite;
    assign cfg       = cfg_reg;

    // Register write decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_index)
                REG_EST_MAX_AGE:   cfg_next.est_max_age   = pwdata;
                REG_CMD_MAX_AGE:   cfg_next.cmd_max_age   = pwdata;
                REG_TARGET_PERIOD: cfg_next.target_period = pwdata;
                REG_CHECK_ENABLES: cfg_next.enables       = pwdata[ENABLE_BITS-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.est_max_age   <= RST_MAX_AGE;
            cfg_reg.cmd_max_age   <= RST_MAX_AGE;
            cfg_reg.target_period <= RST_TARGET_PERIOD;
            cfg_reg.enables       <= RST_ENABLES;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Register read mux.
    always_comb
    begin
        unique case (reg_index)
            REG_EST_MAX_AGE:   prdata = cfg_reg.est_max_age;
            REG_CMD_MAX_AGE:   prdata = cfg_reg.cmd_max_age;
            REG_TARGET_PERIOD: prdata = cfg_reg.target_period;
            REG_CHECK_ENABLES: prdata = CFG_BITS'(cfg_reg.enables);
            default:           prdata = '0;
        endcase
    end

endmodule

// ===== hdl/dsfg_lane.sv =====
module dsfg_lane
    import dsfg_pkg::*;
#(
    parameter int TIME_BITS = 48,
    parameter int ID_BITS   = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  pipe_ctrl_t            ctrl,
    input  logic [CFG_BITS-1:0]   max_age,
    input  logic [2:0]            enables,
    input  logic [TIME_BITS-1:0]  now,
    input  logic [TIME_BITS-1:0]  stamp,
    input  logic [ID_BITS-1:0]    id,
    output logic [CAUSE_BITS-1:0] causes
);

    logic [ID_BITS-1:0]    last_id_reg;
    logic [ID_BITS-1:0]    last_id_next;
    logic [CAUSE_BITS-1:0] causes_reg;
    logic [CAUSE_BITS-1:0] causes_next;
    logic [TIME_BITS-1:0]  age;
    logic                  stamp_zero;
    logic                  id_zero;

    assign stamp_zero = (stamp == '0);
    assign id_zero    = (id == '0);
    assign age        = now - stamp;

    // Freshness checks on one stream. A future stamp (negative age) is never too old.
    always_comb
    begin
        causes_next                  = '0;
        causes_next[CAUSE_MISSING]   = enables[EN_STAMP] && stamp_zero;
        causes_next[CAUSE_TOO_OLD]   = !stamp_zero && !age[TIME_BITS-1]
                                       && (age > TIME_BITS'(max_age));
        causes_next[CAUSE_ZERO_ID]   = enables[EN_ID] && id_zero;
        causes_next[CAUSE_BACKWARDS] = enables[EN_MONO] && !id_zero
                                       && (last_id_reg != '0) && (id < last_id_reg);
    end

    // A nonzero id on a loaded word becomes the new reference.
    assign last_id_next = (ctrl.load && !id_zero) ? id : last_id_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_id_reg <= '0;
        end
        else
        begin
            last_id_reg <= last_id_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            causes_reg <= causes_next;
        end
    end

    assign causes = causes_reg;

endmodule

// ===== hdl/dsfg_timing.sv =====
module dsfg_timing
    import dsfg_pkg::*;
#(
    parameter int TIME_BITS = 48
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  pipe_ctrl_t           ctrl,
    input  logic [CFG_BITS-1:0]  target_period,
    input  logic [TIME_BITS-1:0] now,
    output logic [TIME_BITS-1:0] step_interval,
    output logic [TIME_BITS-1:0] interval_sum,
    output logic [TIME_BITS-1:0] max_jitter
);

    logic [TIME_BITS-1:0] prev_tick_reg;
    logic                 have_prev_reg;
    logic [TIME_BITS-1:0] s1_interval_reg;
    logic [TIME_BITS-1:0] s1_interval_next;
    logic                 s1_measured_reg;
    logic [TIME_BITS-1:0] interval_out_reg;
    logic [TIME_BITS-1:0] sum_reg;
    logic [TIME_BITS-1:0] sum_next;
    logic [TIME_BITS-1:0] peak_reg;
    logic [TIME_BITS-1:0] peak_next;
    logic [TIME_BITS-1:0] target_ext;
    logic [TIME_BITS-1:0] jitter;

    // First stage: interval since the previous tick, zero on the first one.
    assign s1_interval_next = have_prev_reg ? (now - prev_tick_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_tick_reg   <= '0;
            have_prev_reg   <= 1'b0;
            s1_measured_reg <= 1'b0;
        end
        else if (ctrl.load)
        begin
            prev_tick_reg   <= now;
            have_prev_reg   <= 1'b1;
            s1_measured_reg <= have_prev_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            s1_interval_reg <= s1_interval_next;
        end
    end

    // Second stage: running sum and jitter peak.
    assign target_ext = TIME_BITS'(target_period);
    assign jitter     = (s1_interval_reg > target_ext) ? (s1_interval_reg - target_ext)
                                                       : (target_ext - s1_interval_reg);

    always_comb
    begin
        sum_next  = sum_reg;
        peak_next = peak_reg;
        if (ctrl.retire && s1_measured_reg)
        begin
            sum_next = sum_reg + s1_interval_reg;
            if (jitter > peak_reg)
            begin
                peak_next = jitter;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            peak_reg <= '0;
        end
        else
        begin
            sum_reg  <= sum_next;
            peak_reg <= peak_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.retire)
        begin
            interval_out_reg <= s1_interval_reg;
        end
    end

    assign step_interval = interval_out_reg;
    assign interval_sum  = sum_reg;
    assign max_jitter    = peak_reg;

endmodule

// ===== hdl/dual_stream_freshness_gate.sv =====
// An accepted word is held in the first stage, then moves to the output stage.
// Throughput: one word per cycle; the two checking lanes and the interval unit work
// in a two-stage pipeline that stalls only while the output word waits for out_ready.
// Reset (rst_n low, asynchronous): registers return to their reset values, the
// tick history, stored ids, sums and counters clear, and no output word is pending.
module dual_stream_freshness_gate
    import dsfg_pkg::*;
#(
    parameter int TIME_BITS  = 48,
    parameter int ID_BITS    = 32,
    parameter int COUNT_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [CFG_BITS-1:0]   pwdata,
    output logic [CFG_BITS-1:0]   prdata,
    output logic                  pready,
    // Input channel.
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [TIME_BITS-1:0]  now_us,
    input  logic [TIME_BITS-1:0]  est_timestamp_us,
    input  logic [ID_BITS-1:0]    est_seq_id,
    input  logic [TIME_BITS-1:0]  cmd_timestamp_us,
    input  logic [ID_BITS-1:0]    cmd_sample_id,
    // Output channel.
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  est_fresh,
    output logic                  command_valid,
    output logic [1:0]            fault_code,
    output logic [COUNT_BITS-1:0] tick_count,
    output logic [TIME_BITS-1:0]  step_interval_us,
    output logic [TIME_BITS-1:0]  interval_sum_us,
    output logic [TIME_BITS-1:0]  max_jitter_us,
    output logic [CAUSE_BITS-1:0] est_fail_causes,
    output logic [CAUSE_BITS-1:0] cmd_fail_causes,
    output logic [COUNT_BITS-1:0] stale_est_events,
    output logic [COUNT_BITS-1:0] stale_cmd_events
);

    cfg_t                  cfg;
    pipe_ctrl_t            ctrl;
    logic                  advance;
    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [CAUSE_BITS-1:0] est_causes_s1;
    logic [CAUSE_BITS-1:0] cmd_causes_s1;
    logic [CAUSE_BITS-1:0] est_causes_reg;
    logic [CAUSE_BITS-1:0] cmd_causes_reg;
    logic [COUNT_BITS-1:0] tick_reg;
    logic [COUNT_BITS-1:0] est_stale_reg;
    logic [COUNT_BITS-1:0] cmd_stale_reg;

    dsfg_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The whole pipeline moves whenever the output stage is free or being emptied.
    assign advance     = !out_valid_reg || out_ready;
    assign in_ready    = advance;
    assign ctrl.load   = in_valid && advance;
    assign ctrl.retire = s1_valid_reg && advance;

    assign s1_valid_next  = advance ? in_valid : s1_valid_reg;
    assign out_valid_next = advance ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Estimator and command lanes.
    dsfg_lane #(.TIME_BITS(TIME_BITS), .ID_BITS(ID_BITS)) u_est_lane
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .max_age (cfg.est_max_age),
        .enables (cfg.enables[2:0]),
        .now     (now_us),
        .stamp   (est_timestamp_us),
        .id      (est_seq_id),
        .causes  (est_causes_s1)
    );

    dsfg_lane #(.TIME_BITS(TIME_BITS), .ID_BITS(ID_BITS)) u_cmd_lane
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .max_age (cfg.cmd_max_age),
        .enables (cfg.enables[5:3]),
        .now     (now_us),
        .stamp   (cmd_timestamp_us),
        .id      (cmd_sample_id),
        .causes  (cmd_causes_s1)
    );

    // Tick interval, interval sum and jitter peak.
    dsfg_timing #(.TIME_BITS(TIME_BITS)) u_timing
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .target_period (cfg.target_period),
        .now           (now_us),
        .step_interval (step_interval_us),
        .interval_sum  (interval_sum_us),
        .max_jitter    (max_jitter_us)
    );

    // Merge stage: tick and stale counters follow the lane results.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg      <= '0;
            est_stale_reg <= '0;
            cmd_stale_reg <= '0;
        end
        else if (ctrl.retire)
        begin
            tick_reg <= tick_reg + 1'b1;
            if (est_causes_s1 != '0)
            begin
                est_stale_reg <= est_stale_reg + 1'b1;
            end
            if (cmd_causes_s1 != '0)
            begin
                cmd_stale_reg <= cmd_stale_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.retire)
        begin
            est_causes_reg <= est_causes_s1;
            cmd_causes_reg <= cmd_causes_s1;
        end
    end

    // Validity and fault code; an estimator failure takes priority.
    always_comb
    begin
        est_fresh     = (est_causes_reg == '0);
        command_valid = (cmd_causes_reg == '0);
        if (!est_fresh)
        begin
            fault_code = FAULT_EST_INVALID;
        end
        else if (!command_valid)
        begin
            fault_code = FAULT_CMD_TIMEOUT;
        end
        else
        begin
            fault_code = FAULT_NONE;
        end
    end

    assign out_valid        = out_valid_reg;
    assign tick_count       = tick_reg;
    assign est_fail_causes  = est_causes_reg;
    assign cmd_fail_causes  = cmd_causes_reg;
    assign stale_est_events = est_stale_reg;
    assign stale_cmd_events = cmd_stale_reg;

endmodule

// ===== hdl/dsfg_checker.sv =====
module dsfg_checker
    import dsfg_pkg::*;
#(
    parameter int TIME_BITS  = 48,
    parameter int COUNT_BITS = 32
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic                  est_fresh,
    input logic                  command_valid,
    input logic [1:0]            fault_code,
    input logic [COUNT_BITS-1:0] tick_count,
    input logic [TIME_BITS-1:0]  interval_sum_us,
    input logic [CAUSE_BITS-1:0] est_fail_causes
);

    // A stalled output word holds its tick number and sum.
    property p_stall_hold;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(tick_count)
                                    && $stable(interval_sum_us);
    endproperty
    a_stall_hold: assert property (p_stall_hold)
        else $error("output word changed while stalled");

    // A full, stalled output stage must hold off the input side.
    property p_backpressure;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready;
    endproperty
    a_backpressure: assert property (p_backpressure)
        else $error("input accepted while output stage is blocked");

    // Estimator validity agrees with its cause bitmap.
    property p_est_valid;
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> est_fresh == (est_fail_causes == '0);
    endproperty
    a_est_valid: assert property (p_est_valid)
        else $error("estimator validity disagrees with its causes");

    // Fault code follows the validity bits with estimator priority.
    property p_fault_code;
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> ((fault_code == FAULT_EST_INVALID) == !est_fresh)
                      && ((fault_code == FAULT_CMD_TIMEOUT) == (est_fresh && !command_valid))
                      && ((fault_code == FAULT_NONE) == (est_fresh && command_valid));
    endproperty
    a_fault_code: assert property (p_fault_code)
        else $error("fault code inconsistent with validity bits");

endmodule

bind dual_stream_freshness_gate dsfg_checker #(
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS)
) u_dsfg_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .est_fresh       (est_fresh),
    .command_valid   (command_valid),
    .fault_code      (fault_code),
    .tick_count      (tick_count),
    .interval_sum_us (interval_sum_us),
    .est_fail_causes (est_fail_causes)
);

// ===== tb/sv/dual_stream_freshness_gate_tb.sv =====
module dual_stream_freshness_gate_tb
    import dsfg_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TIME_W       = 48;
    localparam int ID_W         = 32;
    localparam int CNT_W        = 32;
    localparam int CMD_EN_SHIFT = 3;
    localparam int LONG_HOLD    = 200;
    localparam int DRAIN_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 200000;

    // One control tick as offered on the input channel.
    typedef struct packed {
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] est_stamp;
        logic [ID_W-1:0]   est_id;
        logic [TIME_W-1:0] cmd_stamp;
        logic [ID_W-1:0]   cmd_id;
    } tick_word_t;

    // One gate verdict as seen on the output channel.
    typedef struct packed {
        logic                  est_ok;
        logic                  cmd_ok;
        logic [1:0]            fault;
        logic [CNT_W-1:0]      ticks;
        logic [TIME_W-1:0]     interval;
        logic [TIME_W-1:0]     interval_sum;
        logic [TIME_W-1:0]     jitter_peak;
        logic [CAUSE_BITS-1:0] est_causes;
        logic [CAUSE_BITS-1:0] cmd_causes;
        logic [CNT_W-1:0]      est_stale;
        logic [CNT_W-1:0]      cmd_stale;
    } verdict_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [3:0]            paddr = '0;
    logic [CFG_BITS-1:0]   pwdata = '0;
    logic [CFG_BITS-1:0]   prdata;
    logic                  pready;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [TIME_W-1:0]     now_us = '0;
    logic [TIME_W-1:0]     est_timestamp_us = '0;
    logic [ID_W-1:0]       est_seq_id = '0;
    logic [TIME_W-1:0]     cmd_timestamp_us = '0;
    logic [ID_W-1:0]       cmd_sample_id = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  est_fresh;
    logic                  command_valid;
    logic [1:0]            fault_code;
    logic [CNT_W-1:0]      tick_count;
    logic [TIME_W-1:0]     step_interval_us;
    logic [TIME_W-1:0]     interval_sum_us;
    logic [TIME_W-1:0]     max_jitter_us;
    logic [CAUSE_BITS-1:0] est_fail_causes;
    logic [CAUSE_BITS-1:0] cmd_fail_causes;
    logic [CNT_W-1:0]      stale_est_events;
    logic [CNT_W-1:0]      stale_cmd_events;

    dual_stream_freshness_gate #(
        .TIME_BITS  (TIME_W),
        .ID_BITS    (ID_W),
        .COUNT_BITS (CNT_W)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .now_us           (now_us),
        .est_timestamp_us (est_timestamp_us),
        .est_seq_id       (est_seq_id),
        .cmd_timestamp_us (cmd_timestamp_us),
        .cmd_sample_id    (cmd_sample_id),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .est_fresh        (est_fresh),
        .command_valid    (command_valid),
        .fault_code       (fault_code),
        .tick_count       (tick_count),
        .step_interval_us (step_interval_us),
        .interval_sum_us  (interval_sum_us),
        .max_jitter_us    (max_jitter_us),
        .est_fail_causes  (est_fail_causes),
        .cmd_fail_causes  (cmd_fail_causes),
        .stale_est_events (stale_est_events),
        .stale_cmd_events (stale_cmd_events)
    );

    // Register copies kept by the predictor.
    logic [CFG_BITS-1:0]    cfg_est_age   = RST_MAX_AGE;
    logic [CFG_BITS-1:0]    cfg_cmd_age   = RST_MAX_AGE;
    logic [CFG_BITS-1:0]    cfg_target    = RST_TARGET_PERIOD;
    logic [ENABLE_BITS-1:0] cfg_enables   = RST_ENABLES;

    // Predictor state: tick history, stored ids, sums and counters.
    logic [TIME_W-1:0] last_tick_time = '0;
    logic              tick_seen      = 1'b0;
    logic [ID_W-1:0]   est_last_id    = '0;
    logic [ID_W-1:0]   cmd_last_id    = '0;
    logic [CNT_W-1:0]  ticks_total    = '0;
    logic [TIME_W-1:0] interval_acc   = '0;
    logic [TIME_W-1:0] jitter_max     = '0;
    logic [CNT_W-1:0]  est_stale_cnt  = '0;
    logic [CNT_W-1:0]  cmd_stale_cnt  = '0;

    // Stimulus generator state for well-formed tick sequences.
    logic [TIME_W-1:0] gen_now    = '0;
    logic [ID_W-1:0]   gen_est_id = '0;
    logic [ID_W-1:0]   gen_cmd_id = '0;

    tick_word_t pending_words[$];
    verdict_t   expected_verdicts[$];
    tick_word_t offered_word;
    verdict_t   want;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         hold_req = 0;
    int         hold_seen = 0;
    int         hold_left = 0;
    int         mismatch_count = 0;
    int         cycle_count = 0;

    // Fault bitmap of one stream for one tick.
    function automatic logic [CAUSE_BITS-1:0] stream_faults(
        input logic [TIME_W-1:0]   now,
        input logic [TIME_W-1:0]   stamp,
        input logic [ID_W-1:0]     id,
        input logic [ID_W-1:0]     last_id,
        input logic [CFG_BITS-1:0] max_age,
        input logic [2:0]          en
    );
        logic [TIME_W-1:0]     age;
        logic [CAUSE_BITS-1:0] c;
        c = '0;
        age = now - stamp;
        if (en[EN_STAMP] && stamp == '0)
            c[CAUSE_MISSING] = 1'b1;
        // A negative age means a stamp from the future, which is never too old.
        if (stamp != '0 && !age[TIME_W-1] && age > TIME_W'(max_age))
            c[CAUSE_TOO_OLD] = 1'b1;
        if (en[EN_ID] && id == '0)
            c[CAUSE_ZERO_ID] = 1'b1;
        if (en[EN_MONO] && id != '0 && last_id != '0 && id < last_id)
            c[CAUSE_BACKWARDS] = 1'b1;
        return c;
    endfunction

    // Advances the predicted gate state by one tick and returns its verdict.
    function automatic verdict_t freshness_tick(input tick_word_t w);
        verdict_t          v;
        logic [TIME_W-1:0] step;
        logic [TIME_W-1:0] dev;
        step = '0;
        if (tick_seen)
        begin
            step = w.now - last_tick_time;
            interval_acc = interval_acc + step;
            dev = (step > TIME_W'(cfg_target)) ? step - TIME_W'(cfg_target)
                                               : TIME_W'(cfg_target) - step;
            if (dev > jitter_max)
                jitter_max = dev;
        end
        last_tick_time = w.now;
        tick_seen = 1'b1;

        v.est_causes = stream_faults(w.now, w.est_stamp, w.est_id, est_last_id,
                                     cfg_est_age, cfg_enables[2:0]);
        v.cmd_causes = stream_faults(w.now, w.cmd_stamp, w.cmd_id, cmd_last_id,
                                     cfg_cmd_age, cfg_enables[CMD_EN_SHIFT +: 3]);
        if (w.est_id != '0)
            est_last_id = w.est_id;
        if (w.cmd_id != '0)
            cmd_last_id = w.cmd_id;

        v.est_ok = (v.est_causes == '0);
        v.cmd_ok = (v.cmd_causes == '0);
        if (!v.est_ok)
            est_stale_cnt = est_stale_cnt + 1'b1;
        if (!v.cmd_ok)
            cmd_stale_cnt = cmd_stale_cnt + 1'b1;
        ticks_total = ticks_total + 1'b1;

        v.fault = !v.est_ok ? FAULT_EST_INVALID :
                  (!v.cmd_ok ? FAULT_CMD_TIMEOUT : FAULT_NONE);
        v.ticks = ticks_total;
        v.interval = step;
        v.interval_sum = interval_acc;
        v.jitter_peak = jitter_max;
        v.est_stale = est_stale_cnt;
        v.cmd_stale = cmd_stale_cnt;
        return v;
    endfunction

    function automatic logic [TIME_W-1:0] rand48();
        return {16'($urandom_range(0, 65535)), 32'($urandom)};
    endfunction

    // Picks a sample age clustered around the limit, with some future stamps.
    function automatic logic [TIME_W-1:0] pick_age(input logic [CFG_BITS-1:0] limit);
        logic [63:0] span;
        span = {32'd0, limit} + 64'd1;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return TIME_W'(limit);
            2: return TIME_W'(limit) + 1'b1;
            6: return TIME_W'(limit) + TIME_W'($urandom_range(1, 1000));
            7: return TIME_W'(0) - TIME_W'($urandom_range(1, 1000));
            8: return rand48();
            9: return TIME_W'($urandom_range(0, 50));
            default: return TIME_W'({$urandom, $urandom} % span);
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] pick_stamp(
        input logic [TIME_W-1:0]   now,
        input logic [CFG_BITS-1:0] limit
    );
        if ($urandom_range(0, 11) == 0)
            return '0;
        return now - pick_age(limit);
    endfunction

    // Mostly rising ids, with zeros, repeats, steps back and wild jumps.
    function automatic logic [ID_W-1:0] pick_id(input logic [ID_W-1:0] last);
        case ($urandom_range(0, 15))
            0: return '0;
            1: return last - ID_W'($urandom_range(1, 100));
            2: return ID_W'($urandom);
            3: return last;
            default: return last + ID_W'($urandom_range(1, 3));
        endcase
    endfunction

    function automatic tick_word_t next_tick_word();
        tick_word_t w;
        // Noise words: every field random, stamps now and then zero.
        if ($urandom_range(0, 99) < 15)
        begin
            w.now = rand48();
            w.est_stamp = ($urandom_range(0, 7) == 0) ? '0 : rand48();
            w.est_id = ID_W'($urandom);
            w.cmd_stamp = ($urandom_range(0, 7) == 0) ? '0 : rand48();
            w.cmd_id = ID_W'($urandom);
            return w;
        end
        // Well-formed tick near the target period, now and then a jump.
        case ($urandom_range(0, 19))
            0: gen_now = rand48();
            1: gen_now = gen_now - TIME_W'($urandom_range(1, 5000));
            default: gen_now = gen_now + TIME_W'(cfg_target)
                               + TIME_W'($urandom_range(0, 40)) - TIME_W'(20);
        endcase
        w.now = gen_now;
        w.est_stamp = pick_stamp(gen_now, cfg_est_age);
        w.cmd_stamp = pick_stamp(gen_now, cfg_cmd_age);
        w.est_id = pick_id(gen_est_id);
        w.cmd_id = pick_id(gen_cmd_id);
        if (w.est_id != '0)
            gen_est_id = w.est_id;
        if (w.cmd_id != '0)
            gen_cmd_id = w.cmd_id;
        return w;
    endfunction

    task automatic queue_word(
        input logic [TIME_W-1:0] now,
        input logic [TIME_W-1:0] ets,
        input logic [ID_W-1:0]   eid,
        input logic [TIME_W-1:0] cts,
        input logic [ID_W-1:0]   cid
    );
        tick_word_t w;
        w.now = now;
        w.est_stamp = ets;
        w.est_id = eid;
        w.cmd_stamp = cts;
        w.cmd_id = cid;
        pending_words.push_back(w);
    endtask

    task automatic feed_words(input int count);
        for (int i = 0; i < count; i++)
            pending_words.push_back(next_tick_word());
    endtask

    // Waits until every queued word has been accepted and answered.
    task automatic drain_all();
        do
            @(posedge clk);
        while (pending_words.size() != 0 || expected_verdicts.size() != 0 || in_valid);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Setup and access cycle; the register takes the value at the access edge.
    task automatic apb_write(input logic [1:0] idx, input logic [CFG_BITS-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_EST_MAX_AGE:   cfg_est_age = value;
            REG_CMD_MAX_AGE:   cfg_cmd_age = value;
            REG_TARGET_PERIOD: cfg_target = value;
            REG_CHECK_ENABLES: cfg_enables = value[ENABLE_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(
        input logic [CFG_BITS-1:0]    est_age,
        input logic [CFG_BITS-1:0]    cmd_age,
        input logic [CFG_BITS-1:0]    target,
        input logic [ENABLE_BITS-1:0] en
    );
        apb_write(REG_EST_MAX_AGE, est_age);
        apb_write(REG_CMD_MAX_AGE, cmd_age);
        apb_write(REG_TARGET_PERIOD, target);
        apb_write(REG_CHECK_ENABLES, CFG_BITS'(en));
    endtask

    task automatic check_field(
        input string       name,
        input logic [63:0] exp_val,
        input logic [63:0] act_val
    );
        if (act_val !== exp_val)
        begin
            $error("%s: expected %0h, got %0h", name, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    // Clock generation.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Input driver: offers queued words, idling at random between them.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_verdicts.push_back(freshness_tick(offered_word));
            if (!in_valid || in_ready)
            begin
                if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    offered_word = pending_words.pop_front();
                    in_valid <= 1'b1;
                    now_us <= offered_word.now;
                    est_timestamp_us <= offered_word.est_stamp;
                    est_seq_id <= offered_word.est_id;
                    cmd_timestamp_us <= offered_word.cmd_stamp;
                    cmd_sample_id <= offered_word.cmd_id;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: checks each accepted word and throttles out_ready.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    $error("output word with no tick awaiting a verdict");
                    mismatch_count++;
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    check_field("est_fresh", 64'(want.est_ok), 64'(est_fresh));
                    check_field("command_valid", 64'(want.cmd_ok), 64'(command_valid));
                    check_field("fault_code", 64'(want.fault), 64'(fault_code));
                    check_field("tick_count", 64'(want.ticks), 64'(tick_count));
                    check_field("step_interval_us", 64'(want.interval),
                                64'(step_interval_us));
                    check_field("interval_sum_us", 64'(want.interval_sum),
                                64'(interval_sum_us));
                    check_field("max_jitter_us", 64'(want.jitter_peak), 64'(max_jitter_us));
                    check_field("est_fail_causes", 64'(want.est_causes),
                                64'(est_fail_causes));
                    check_field("cmd_fail_causes", 64'(want.cmd_causes),
                                64'(cmd_fail_causes));
                    check_field("stale_est_events", 64'(want.est_stale),
                                64'(stale_est_events));
                    check_field("stale_cmd_events", 64'(want.cmd_stale),
                                64'(stale_cmd_events));
                end
            end
            // A long hold-off lets the pipeline fill and push back on the input.
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("dual_stream_freshness_gate verification failed");
            $finish;
        end
    end

    // Stimulus sequence.
    initial
    begin
        send_idle_pct = 14;
        recv_idle_pct = 46;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed ticks under the reset configuration.
        // First tick at time zero with both streams missing.
        queue_word('0, '0, '0, '0, '0);
        queue_word(48'd2000, 48'd2000, 32'd5, 48'd1, 32'd5);
        // Age exactly at the limit passes, one past it fails.
        queue_word(48'd4000, 48'd4000 - 48'd100000, 32'd6,
                   48'd4000 - 48'd100001, 32'd6);
        // Stamp from the future, estimator id backwards, command id zero.
        queue_word(48'd6000, 48'd7000, 32'd4, 48'd6000, 32'd0);
        // Zero estimator id keeps the stored id; command id backwards.
        queue_word(48'd8000, 48'd8000, 32'd0, 48'd8000, 32'd3);
        queue_word(48'd10000, 48'd10000, 32'd3, 48'd10000, 32'd7);
        // Time going backwards.
        queue_word(48'd9000, 48'd9000, 32'd8, 48'd9000, 32'd8);
        // All ones in every field.
        queue_word('1, '1, '1, '1, '1);
        // Time wrapping forward, stamp across the wrap.
        queue_word(48'd5, 48'hFFFF_FFFF_FFF0, 32'd1, 48'd5, 32'd0);
        // Age with the sign bit set is not too old; one less is.
        queue_word(48'h8000_0000_0100, 48'h0000_0000_0100, 32'd10,
                   48'h0000_0000_0101, 32'd10);
        // Only the command stream fails.
        queue_word(48'h8000_0000_0900, 48'h8000_0000_0900, 32'd11, '0, 32'd11);
        queue_word(48'h8000_0000_1100, 48'h8000_0000_10FF, 32'd12,
                   48'h8000_0000_10FF, 32'd12);
        // Zero interval and repeated ids.
        queue_word(48'h8000_0000_1100, 48'h8000_0000_1100, 32'd12,
                   48'h8000_0000_1100, 32'd12);
        drain_all();

        // Tight limits, all checks on, with one long receiver hold-off.
        configure(32'd5000, 32'd3000, 32'd1000, 6'h3F);
        gen_now = rand48();
        gen_est_id = ID_W'($urandom_range(1, 1000));
        gen_cmd_id = ID_W'($urandom_range(1, 1000));
        feed_words(60);
        hold_req++;
        feed_words(190);
        drain_all();

        // Zero limits and period, every enable bit clear; the age check stays on.
        configure('0, '0, '0, '0);
        gen_now = 48'hFFFF_FFFF_FFFF - 48'd200;
        gen_est_id = 32'hFFFF_FFF0;
        gen_cmd_id = 32'hFFFF_FFF8;
        feed_words(250);
        drain_all();

        // Largest limits and period; the sender pauses once for a full drain.
        send_idle_pct = 46;
        recv_idle_pct = 14;
        configure('1, '1, '1, 6'h15);
        gen_now = rand48();
        gen_est_id = ID_W'($urandom);
        gen_cmd_id = ID_W'($urandom);
        feed_words(125);
        drain_all();
        feed_words(125);
        drain_all();

        // Random configuration at full rate.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        configure(CFG_BITS'($urandom_range(0, 200000)), CFG_BITS'($urandom_range(0, 200000)),
                  CFG_BITS'($urandom_range(0, 5000)), ENABLE_BITS'($urandom_range(0, 63)));
        gen_now = rand48();
        gen_est_id = ID_W'($urandom);
        gen_cmd_id = ID_W'($urandom);
        feed_words(250);
        drain_all();

        if (expected_verdicts.size() != 0)
        begin
            $error("%0d ticks still awaiting a verdict", expected_verdicts.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("dual_stream_freshness_gate verification clean");
        else
            $display("dual_stream_freshness_gate verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/dsfg_pkg.sv
hdl/dsfg_cfg.sv
hdl/dsfg_lane.sv
hdl/dsfg_timing.sv
hdl/dual_stream_freshness_gate.sv
hdl/dsfg_checker.sv
tb/sv/dual_stream_freshness_gate_tb.sv
